// ----- src/s2l_pkg.sv -----
package s2l_pkg;

	localparam logic [11:0] BASE_YEAR      = 12'd2000;
	localparam logic [11:0] SKIP_LEAP_YEAR = 12'd2100;
	localparam logic [16:0] BASE_DAY_INDEX = 17'd35;
	localparam logic [3:0]  FIRST_ANIMAL   = 4'd5;
	localparam logic [3:0]  FIRST_STEM     = 4'd7;
	localparam logic [3:0]  MONTHS_IN_YEAR = 4'd12;
	localparam logic [3:0]  ANIMAL_COUNT   = 4'd12;
	localparam logic [3:0]  STEM_COUNT     = 4'd10;
	localparam logic [8:0]  DAYS_YEAR      = 9'd365;
	localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
	localparam logic [4:0]  SHORT_MONTH    = 5'd29;
	localparam logic [4:0]  LONG_MONTH     = 5'd30;

	typedef enum logic [2:0] {
		S_IDLE,
		S_YEARS,
		S_MONTHS,
		S_CHECK,
		S_WALK
	} s2l_state_t;

	typedef struct packed {
		logic [16:0] sum;
		logic        reached;
	} s2l_unit_out_t;

	// Valid for the years this block accepts with the default table, 2000 through 2100.
	function automatic logic greg_leap(input logic [11:0] y);
		return (y[1:0] == 2'd0) && (y != SKIP_LEAP_YEAR);
	endfunction

	function automatic logic [4:0] greg_month_days(input logic [11:0] y, input logic [3:0] m);
		logic [4:0] n;
		n = 5'd31;
		if (m == 4'd2)
			n = greg_leap(y) ? 5'd29 : 5'd28;
		else if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
			n = 5'd30;
		return n;
	endfunction

	function automatic logic [16:0] year_entry(input logic [6:0] idx);
		logic [16:0] e;
		case (idx)
			7'd0: e = 17'h0c960;  7'd1: e = 17'h0d954;  7'd2: e = 17'h0d4a0;  7'd3: e = 17'h0da50;
			7'd4: e = 17'h07552;  7'd5: e = 17'h056a0;  7'd6: e = 17'h0abb7;  7'd7: e = 17'h025d0;
			7'd8: e = 17'h092d0;  7'd9: e = 17'h0cab5;  7'd10: e = 17'h0a950; 7'd11: e = 17'h0b4a0;
			7'd12: e = 17'h0baa4; 7'd13: e = 17'h0ad50; 7'd14: e = 17'h055d9; 7'd15: e = 17'h04ba0;
			7'd16: e = 17'h0a5b0; 7'd17: e = 17'h15176; 7'd18: e = 17'h052b0; 7'd19: e = 17'h0a930;
			7'd20: e = 17'h07954; 7'd21: e = 17'h06aa0; 7'd22: e = 17'h0ad50; 7'd23: e = 17'h05b52;
			7'd24: e = 17'h04b60; 7'd25: e = 17'h0a6e6; 7'd26: e = 17'h0a4e0; 7'd27: e = 17'h0d260;
			7'd28: e = 17'h0ea65; 7'd29: e = 17'h0d530; 7'd30: e = 17'h05aa0; 7'd31: e = 17'h076a3;
			7'd32: e = 17'h096d0; 7'd33: e = 17'h04afb; 7'd34: e = 17'h04ad0; 7'd35: e = 17'h0a4d0;
			7'd36: e = 17'h1d0b6; 7'd37: e = 17'h0d250; 7'd38: e = 17'h0d520; 7'd39: e = 17'h0dd45;
			7'd40: e = 17'h0b5a0; 7'd41: e = 17'h056d0; 7'd42: e = 17'h055b2; 7'd43: e = 17'h049b0;
			7'd44: e = 17'h0a577; 7'd45: e = 17'h0a4b0; 7'd46: e = 17'h0aa50; 7'd47: e = 17'h1b255;
			7'd48: e = 17'h06d20; 7'd49: e = 17'h0ada0; 7'd50: e = 17'h14b63; 7'd51: e = 17'h09370;
			7'd52: e = 17'h049f8; 7'd53: e = 17'h04970; 7'd54: e = 17'h064b0; 7'd55: e = 17'h168a6;
			7'd56: e = 17'h0ea50; 7'd57: e = 17'h06aa0; 7'd58: e = 17'h1a6c4; 7'd59: e = 17'h0aae0;
			7'd60: e = 17'h092e0; 7'd61: e = 17'h0d2e3; 7'd62: e = 17'h0c960; 7'd63: e = 17'h0d557;
			7'd64: e = 17'h0d4a0; 7'd65: e = 17'h0da50; 7'd66: e = 17'h05d55; 7'd67: e = 17'h056a0;
			7'd68: e = 17'h0a6d0; 7'd69: e = 17'h055d4; 7'd70: e = 17'h052d0; 7'd71: e = 17'h0a9b8;
			7'd72: e = 17'h0a950; 7'd73: e = 17'h0b4a0; 7'd74: e = 17'h0b6a6; 7'd75: e = 17'h0ad50;
			7'd76: e = 17'h055a0; 7'd77: e = 17'h0aba4; 7'd78: e = 17'h0a5b0; 7'd79: e = 17'h052b0;
			7'd80: e = 17'h0b273; 7'd81: e = 17'h06930; 7'd82: e = 17'h07337; 7'd83: e = 17'h06aa0;
			7'd84: e = 17'h0ad50; 7'd85: e = 17'h14b55; 7'd86: e = 17'h04b60; 7'd87: e = 17'h0a570;
			7'd88: e = 17'h054e4; 7'd89: e = 17'h0d160; 7'd90: e = 17'h0e968; 7'd91: e = 17'h0d520;
			7'd92: e = 17'h0daa0; 7'd93: e = 17'h16aa6; 7'd94: e = 17'h056d0; 7'd95: e = 17'h04ae0;
			7'd96: e = 17'h0a9d4; 7'd97: e = 17'h0a2d0; 7'd98: e = 17'h0d150; 7'd99: e = 17'h0f252;
			default: e = 17'h00000;
		endcase
		return e;
	endfunction

endpackage

// ----- src/solar_to_lunar_date.sv -----
// Converts a Gregorian date from 2000-02-05 onward into the Chinese lunar month, day,
// leap-month flag, zodiac animal and heavenly stem, from a built-in table of lunar years.
// While one item is worked on, busy stays high through the year steps from 2000 to greg_year,
// the month steps of that year up to greg_month, a check, and the lunar months walked from
// the first month of lunar 2000 through the month that holds the date. A single shared adder
// adds one year length, one month length or one lunar month length per cycle. The result
// follows in the next cycle. An invalid calendar date keeps busy low and gives its result in
// the cycle right after the item. The result shows for one cycle with done high and must be
// taken then, since the receiver cannot hold it. Start is ignored while busy is high; busy
// is low again in the cycle of done.
module solar_to_lunar_date #(
	parameter int TABLE_YEARS = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] greg_year,
	input  logic [3:0]  greg_month,
	input  logic [4:0]  greg_day,
	output logic        done,
	output logic [3:0]  lunar_month,
	output logic [4:0]  lunar_day,
	output logic        in_leap_month,
	output logic [3:0]  zodiac_animal,
	output logic [3:0]  heavenly_stem,
	output logic        status
);
	import s2l_pkg::*;

	localparam int IDX_W = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;
	localparam logic [11:0] YEAR_LAST = 12'(2000 + TABLE_YEARS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_YEARS - 1);
	localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

	s2l_state_t state_q, state_d;

	logic [11:0] year_q, year_d;
	logic [3:0]  month_q, month_d;
	logic [11:0] ycnt_q, ycnt_d;
	logic [3:0]  mcnt_q, mcnt_d;
	logic [16:0] acc_q, acc_d;
	logic [15:0] target_q, target_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [3:0]  lm_q, lm_d;
	logic        leap_q, leap_d;
	logic [3:0]  animal_q, animal_d;
	logic [3:0]  stem_q, stem_d;

	logic        done_q, done_d;
	logic        res_load, res_err;
	logic [4:0]  res_day;

	logic [8:0]  addend;
	s2l_unit_out_t unit;

	logic        bad_in;
	logic [16:0] entry;
	logic [11:0] mbits;
	logic [4:0]  mlen;
	logic        enter_leap;

	s2l_acc_unit u_acc (
		.acc    (acc_q),
		.addend (addend),
		.target (target_q),
		.res    (unit)
	);

	assign bad_in = (greg_year < BASE_YEAR) || (greg_year > YEAR_LAST) ||
		(greg_month == 4'd0) || (greg_month > MONTHS_IN_YEAR) || (greg_day == 5'd0) ||
		(greg_day > greg_month_days(greg_year, greg_month));

	assign entry = year_entry(7'(idx_q));
	assign mbits = entry[15:4];
	assign mlen = leap_q ? (entry[16] ? LONG_MONTH : SHORT_MONTH) :
		(mbits[4'(MONTHS_IN_YEAR - lm_q)] ? LONG_MONTH : SHORT_MONTH);
	assign enter_leap = !leap_q && (entry[3:0] == lm_q);

	always_comb begin
		state_d  = state_q;
		year_d   = year_q;
		month_d  = month_q;
		ycnt_d   = ycnt_q;
		mcnt_d   = mcnt_q;
		acc_d    = acc_q;
		target_d = target_q;
		idx_d    = idx_q;
		lm_d     = lm_q;
		leap_d   = leap_q;
		animal_d = animal_q;
		stem_d   = stem_q;
		done_d   = 1'b0;
		res_load = 1'b0;
		res_err  = 1'b0;
		res_day  = 5'(17'(target_q) - acc_q);
		addend   = 9'd0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (bad_in) begin
						done_d   = 1'b1;
						res_load = 1'b1;
						res_err  = 1'b1;
					end else begin
						year_d  = greg_year;
						month_d = greg_month;
						ycnt_d  = BASE_YEAR;
						mcnt_d  = 4'd1;
						acc_d   = 17'(greg_day) - 17'd1;
						state_d = S_YEARS;
					end
				end
			end
			S_YEARS: begin
				addend = greg_leap(ycnt_q) ? DAYS_LEAP_YEAR : DAYS_YEAR;
				if (ycnt_q == year_q) begin
					state_d = S_MONTHS;
				end else begin
					acc_d  = unit.sum;
					ycnt_d = ycnt_q + 12'd1;
				end
			end
			S_MONTHS: begin
				addend = 9'(greg_month_days(year_q, mcnt_q));
				if (mcnt_q == month_q) begin
					state_d = S_CHECK;
				end else begin
					acc_d  = unit.sum;
					mcnt_d = mcnt_q + 4'd1;
				end
			end
			S_CHECK: begin
				if (acc_q < BASE_DAY_INDEX) begin
					done_d   = 1'b1;
					res_load = 1'b1;
					res_err  = 1'b1;
					state_d  = S_IDLE;
				end else begin
					// Counting lunar days from one day before lunar new year 2000.
					target_d = acc_q[15:0];
					acc_d    = BASE_DAY_INDEX - 17'd1;
					idx_d    = '0;
					lm_d     = 4'd1;
					leap_d   = 1'b0;
					animal_d = FIRST_ANIMAL;
					stem_d   = FIRST_STEM;
					state_d  = S_WALK;
				end
			end
			S_WALK: begin
				addend = 9'(mlen);
				if (unit.reached) begin
					done_d   = 1'b1;
					res_load = 1'b1;
					state_d  = S_IDLE;
				end else begin
					acc_d = unit.sum;
					if (enter_leap) begin
						leap_d = 1'b1;
					end else begin
						leap_d = 1'b0;
						lm_d   = lm_q + 4'd1;
						if (lm_q == MONTHS_IN_YEAR) begin
							if (idx_q == IDX_LAST) begin
								done_d   = 1'b1;
								res_load = 1'b1;
								res_err  = 1'b1;
								state_d  = S_IDLE;
							end else begin
								idx_d    = idx_q + IDX_ONE;
								lm_d     = 4'd1;
								animal_d = (animal_q >= ANIMAL_COUNT) ? 4'd1 : animal_q + 4'd1;
								stem_d   = (stem_q >= STEM_COUNT) ? 4'd1 : stem_q + 4'd1;
							end
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		year_q   <= year_d;
		month_q  <= month_d;
		ycnt_q   <= ycnt_d;
		mcnt_q   <= mcnt_d;
		acc_q    <= acc_d;
		target_q <= target_d;
		idx_q    <= idx_d;
		lm_q     <= lm_d;
		leap_q   <= leap_d;
		animal_q <= animal_d;
		stem_q   <= stem_d;
		if (res_load) begin
			if (res_err) begin
				lunar_month   <= 4'd0;
				lunar_day     <= 5'd0;
				in_leap_month <= 1'b0;
				zodiac_animal <= 4'd0;
				heavenly_stem <= 4'd0;
				status        <= 1'b1;
			end else begin
				lunar_month   <= lm_q;
				lunar_day     <= res_day;
				in_leap_month <= leap_q;
				zodiac_animal <= animal_q;
				heavenly_stem <= stem_q;
				status        <= 1'b0;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ----- src/s2l_acc_unit.sv -----
module s2l_acc_unit (
	input  logic [16:0]           acc,
	input  logic [8:0]            addend,
	input  logic [15:0]           target,
	output s2l_pkg::s2l_unit_out_t res
);
	import s2l_pkg::*;

	always_comb begin
		res.sum     = acc + {8'd0, addend};
		res.reached = res.sum >= {1'b0, target};
	end

endmodule

// ----- src/s2l_checker.sv -----
module s2l_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [11:0] greg_year,
	input logic [3:0]  greg_month,
	input logic [4:0]  greg_day,
	input logic        done,
	input logic [3:0]  lunar_month,
	input logic [4:0]  lunar_day,
	input logic        in_leap_month,
	input logic [3:0]  zodiac_animal,
	input logic [3:0]  heavenly_stem,
	input logic        status
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_accept_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || (done && status)))
		else $error("accepted item neither worked on nor rejected");

	a_end_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_ok_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !status) |-> (lunar_month >= 4'd1 && lunar_month <= 4'd12 &&
			lunar_day >= 5'd1 && lunar_day <= 5'd30 &&
			zodiac_animal >= 4'd1 && zodiac_animal <= 4'd12 &&
			heavenly_stem >= 4'd1 && heavenly_stem <= 4'd10))
		else $error("result field out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (lunar_month == 4'd0 && lunar_day == 5'd0 && !in_leap_month &&
			zodiac_animal == 4'd0 && heavenly_stem == 4'd0))
		else $error("error result carries nonzero fields");

endmodule

bind solar_to_lunar_date s2l_checker u_s2l_checker (.*);
